// ----- rtl/nhte_pkg.sv -----
`default_nettype none
package nhte_pkg;

  localparam logic [2:0] ACT_UINT   = 3'd0;
  localparam logic [2:0] ACT_SINT   = 3'd1;
  localparam logic [2:0] ACT_REAL32 = 3'd2;
  localparam logic [2:0] ACT_REAL64 = 3'd3;
  localparam logic [2:0] ACT_BYTE   = 3'd4;

  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_G     = 8'h47;

  // job queue depth, power of two
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] value_bits;
  } item_t;

  typedef struct packed {
    logic [7:0] ascii_char;
    logic       last_char;
  } result_t;

  typedef struct packed {
    logic [63:0] digits;      // nibble 0 is digits[63:60]
    logic [3:0]  start;       // first nibble to emit
    logic        prefix_en;
    logic [7:0]  prefix_char;
    logic        real_alpha;  // G..V instead of 0..F
  } job_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    case (nib)
      4'h0: c = 8'h30;
      4'h1: c = 8'h31;
      4'h2: c = 8'h32;
      4'h3: c = 8'h33;
      4'h4: c = 8'h34;
      4'h5: c = 8'h35;
      4'h6: c = 8'h36;
      4'h7: c = 8'h37;
      4'h8: c = 8'h38;
      4'h9: c = 8'h39;
      4'hA: c = 8'h41;
      4'hB: c = 8'h42;
      4'hC: c = 8'h43;
      4'hD: c = 8'h44;
      4'hE: c = 8'h45;
      default: c = 8'h46;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] real_char(input logic [3:0] nib);
    return CHAR_G + {4'd0, nib};
  endfunction

  // leading zero nibbles of a 64-bit word, 16 when all zero
  function automatic logic [4:0] lead_zero_nibbles(input logic [63:0] w);
    logic [4:0] n;
    n = 5'd16;
    for (int i = 0; i < 16; i++) begin
      if (w[4*i +: 4] != 4'h0) begin
        n = 5'(15 - i);
      end
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/number_hex_token_encoder.sv -----
// Number token encoder: turns a (kind, 64-bit value) word into its text
// token, one ASCII character per result word, last_char set on the final one.
//
// Input side is a queue write port: a word is taken on a clock edge with
// push high and full low. Kinds 5..7 are taken and dropped with no result.
// Result side is a queue read port: while empty is low the oldest character
// sits on result, and it leaves on an edge with pop high.
//
// Flow: with the block idle the first character passes the job queue, the
// job register and the output register after the input word is taken. After
// that one character leaves per cycle while pop is high; a word gives 1 to 17
// characters. The next job loads on the same edge that the previous one ends.
// A two-entry job queue between the classifier and the serializer lets a new
// word be taken while characters of earlier words are still going out.
//
// When the receiver stops popping, the output register holds its character,
// the serializer waits, the job queue fills and full rises.
// Synchronous reset empties the job queue, the serializer and the output
// register; no partial token survives reset.
`default_nettype none
module number_hex_token_encoder (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire nhte_pkg::item_t   item,
  output logic                   empty,
  input  wire logic              pop,
  output nhte_pkg::result_t      result
);

  logic           q_push;
  nhte_pkg::job_t q_job;
  logic           q_full;
  logic           q_valid;
  nhte_pkg::job_t q_head;
  logic           q_pop;

  nhte_front u_front (
    .item   (item),
    .push   (push),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (q_job)
  );

  nhte_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .full     (q_full),
    .valid    (q_valid),
    .head     (q_head)
  );

  nhte_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

  assign full = q_full;

endmodule
`default_nettype wire

// ----- rtl/nhte_front.sv -----
`default_nettype none
module nhte_front (
  input  wire nhte_pkg::item_t item,
  input  wire logic            push,
  input  wire logic            q_full,
  output logic                 q_push,
  output nhte_pkg::job_t       q_job
);

  logic [63:0]    v;
  logic [63:0]    mag;
  logic [63:0]    swp64;
  logic [31:0]    swp32;
  logic [4:0]     lz;
  logic [3:0]     q_job_start;
  logic           known;
  logic           neg;
  nhte_pkg::job_t cls_job;

  assign v   = item.value_bits;
  assign mag = ~v + 64'd1;
  assign swp32 = {v[7:0], v[15:8], v[23:16], v[31:24]};

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      swp64[8*i +: 8] = v[8*(7-i) +: 8];
    end
  end

  always_comb begin
    cls_job             = '0;
    cls_job.prefix_char = nhte_pkg::CHAR_MINUS;
    known               = 1'b1;
    neg                 = 1'b0;
    unique case (item.action) inside
      nhte_pkg::ACT_UINT, nhte_pkg::ACT_SINT: begin
        neg               = (item.action == nhte_pkg::ACT_SINT) && v[63];
        cls_job.digits    = neg ? mag : v;
        cls_job.prefix_en = neg;
      end
      nhte_pkg::ACT_REAL32: begin
        cls_job.real_alpha = 1'b1;
        cls_job.digits     = (v[30:0] == 31'd0) ? 64'd0 : {32'd0, swp32};
      end
      nhte_pkg::ACT_REAL64: begin
        cls_job.real_alpha  = 1'b1;
        cls_job.prefix_char = nhte_pkg::CHAR_G;
        cls_job.digits      = (v[62:0] == 63'd0) ? 64'd0 : swp64;
        // a leading zero nibble in a nonzero word earns a 'G' in front
        cls_job.prefix_en   = (v[62:0] != 63'd0) && (swp64[63:60] == 4'h0);
      end
      nhte_pkg::ACT_BYTE: begin
        cls_job.digits = {56'd0, v[7:0]};
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  assign lz = nhte_pkg::lead_zero_nibbles(cls_job.digits);

  // zero still emits its last nibble; a byte always emits two
  always_comb begin
    if (item.action == nhte_pkg::ACT_BYTE) begin
      q_job_start = 4'd14;
    end else if (lz[4]) begin
      q_job_start = 4'd15;
    end else begin
      q_job_start = lz[3:0];
    end
  end

  always_comb begin
    q_job       = cls_job;
    q_job.start = q_job_start;
  end

  assign q_push = push && !q_full && known;

endmodule
`default_nettype wire

// ----- rtl/nhte_queue.sv -----
`default_nettype none
module nhte_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire nhte_pkg::job_t push_job,
  input  wire logic           pop,
  output logic                full,
  output logic                valid,
  output nhte_pkg::job_t      head
);

  nhte_pkg::job_t                 mem [nhte_pkg::QDEPTH];
  logic [nhte_pkg::QPTR_W-1:0]    wr_ptr;
  logic [nhte_pkg::QPTR_W-1:0]    rd_ptr;
  logic [nhte_pkg::QPTR_W:0]      count;

  assign full  = (count == (nhte_pkg::QPTR_W+1)'(nhte_pkg::QDEPTH));
  assign valid = (count != '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop))
    else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !valid))
    else $error("job queue underflow");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (nhte_pkg::QPTR_W+1)'(nhte_pkg::QDEPTH))
    else $error("job queue count out of range");

endmodule
`default_nettype wire

// ----- rtl/nhte_back.sv -----
`default_nettype none
module nhte_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  wire nhte_pkg::job_t q_head,
  output logic                q_pop,
  input  wire logic           pop,
  output logic                empty,
  output nhte_pkg::result_t   result
);

  nhte_pkg::job_t    job;
  logic              busy;
  logic              pfx_pending;
  logic [3:0]        idx;
  logic              out_valid;
  nhte_pkg::result_t out_word;

  logic              out_load;
  logic              emit;
  logic [3:0]        nib;
  nhte_pkg::result_t ch;

  assign out_load = !out_valid || pop;
  assign emit     = busy && out_load;
  assign nib      = job.digits[{~idx, 2'b00} +: 4];

  always_comb begin
    if (pfx_pending) begin
      ch.ascii_char = job.prefix_char;
      ch.last_char  = 1'b0;
    end else begin
      ch.ascii_char = job.real_alpha ? nhte_pkg::real_char(nib) : nhte_pkg::hex_char(nib);
      ch.last_char  = (idx == 4'd15);
    end
  end

  // next job comes in on the same edge that the current one finishes
  assign q_pop = q_valid && (!busy || (emit && ch.last_char));

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job <= q_head;
    end
    if (emit) begin
      out_word <= ch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      pfx_pending <= 1'b0;
      idx         <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (q_pop) begin
        busy        <= 1'b1;
        pfx_pending <= q_head.prefix_en;
        idx         <= q_head.start;
      end else if (emit) begin
        if (ch.last_char) begin
          busy <= 1'b0;
        end
        if (pfx_pending) begin
          pfx_pending <= 1'b0;
        end else begin
          idx <= idx + 4'd1;
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign empty  = !out_valid;
  assign result = out_word;

  a_pfx_busy: assert property (@(posedge clk) disable iff (rst)
    pfx_pending |-> busy)
    else $error("prefix pending with no job");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (busy && out_valid && !pop) |=> ($stable(idx) && $stable(pfx_pending)))
    else $error("serializer advanced while output stalled");

endmodule
`default_nettype wire
